@@ hw/rtl/pvr_pkg.sv @@
`default_nettype none
package pvr_pkg;

    localparam int MAX_GRID_DEF      = 64;
    localparam int LOOPS_PER_BOX_DEF = 2;
    localparam int BINS_PER_CELL_DEF = 8;
    localparam int GRID_RESET        = 64;
    localparam int HALF_Q16          = 32768;
    localparam int HALF_CELL_SHIFT   = 13;   // half a cell in Q1.14 is 2^13
    localparam int PATH_SHIFT        = 29;   // 2^13 * 2^16 for Q8.16 output

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_TRACE = 1'b1;

    typedef struct packed {
        logic               func;
        logic        [5:0]  cell_x;
        logic        [5:0]  cell_y;
        logic        [5:0]  cell_z;
        logic        [16:0] ion_fraction;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } t_in_word;

    typedef struct packed {
        logic [23:0] path_length;
        logic [9:0]  length_bin;
        logic        hit_limit;
        logic        bad_direction;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_STEP,
        S_CHECK,
        S_DIVP,
        S_DIVB,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic map_wr;
        logic prep;
        logic step;
        logic check;
        logic div_load_path;
        logic div_load_bin;
        logic div_step;
        logic save_path;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic zero_dir;
        logic stop;
        logic limit;
        logic div_done;
    } t_status;

endpackage
`default_nettype wire

@@ hw/rtl/pvr_ctrl.sv @@
`default_nettype none
module pvr_ctrl
    import pvr_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      start,
    input  t_status  i_status,
    output t_cmd     o_cmd,
    output logic     busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.func == FUNC_LOAD) begin
                    o_cmd.map_wr = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_state    = i_status.zero_dir ? S_EMIT : S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_status.stop) begin
                    if (i_status.limit) begin
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.div_load_path = 1'b1;
                        n_state             = S_DIVP;
                    end
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DIVP: begin
                if (i_status.div_done) begin
                    o_cmd.save_path    = 1'b1;
                    o_cmd.div_load_bin = 1'b1;
                    n_state            = S_DIVB;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DIVB: begin
                if (i_status.div_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/pvr_datapath.sv @@
`default_nettype none
module pvr_datapath
    import pvr_pkg::*;
#(
    parameter int MAX_GRID      = MAX_GRID_DEF,
    parameter int LOOPS_PER_BOX = LOOPS_PER_BOX_DEF,
    parameter int BINS_PER_CELL = BINS_PER_CELL_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_in_word   i_item,
    input  wire        i_cfg_wr,
    input  wire  [6:0] i_cfg_data,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    output logic       o_strobe,
    output t_out_word  o_result
);

    localparam int CELL_W    = $clog2(MAX_GRID);
    localparam int GW        = $clog2(MAX_GRID + 1);
    localparam int GL_MAX    = MAX_GRID * LOOPS_PER_BOX;
    localparam int GL_W      = $clog2(GL_MAX + 1);
    localparam int P_W       = $clog2(8 * GL_MAX) + 1;
    localparam int NUM_W     = P_W + 1;
    localparam int MAG_W     = 16;
    localparam int PROD_W    = NUM_W + MAG_W;
    localparam int CMP_W     = GL_W + NUM_W + MAG_W;
    localparam int MAP_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int DIVD_W    = NUM_W + PATH_SHIFT;
    localparam int CNT_W     = $clog2(DIVD_W + 1);
    localparam int BIN_MUL   = (1 << HALF_CELL_SHIFT) * BINS_PER_CELL;

    function automatic logic [CELL_W-1:0] wrap_cell(input logic [5:0] c,
                                                    input logic [GW-1:0] g);
        logic [15:0] r;
        logic [15:0] d;
        r = {10'd0, c};
        for (int k = 5; k >= 0; k--) begin
            d = 16'(g) << k;
            if (r >= d) r = r - d;
        end
        return CELL_W'(r);
    endfunction

    function automatic logic [ADDR_W-1:0] map_addr(input logic [CELL_W-1:0] cx,
                                                   input logic [CELL_W-1:0] cy,
                                                   input logic [CELL_W-1:0] cz);
        logic [31:0] a;
        a = (32'(cx) * 32'(MAX_GRID) + 32'(cy)) * 32'(MAX_GRID) + 32'(cz);
        return ADDR_W'(a);
    endfunction

    // configuration and effective grid
    logic [6:0]     r_grid;
    logic [GW-1:0]  grid;
    logic [GL_W-1:0] gl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= 7'(GRID_RESET);
        end else if (i_cfg_wr) begin
            r_grid <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_grid < 7'd2) begin
            grid = GW'(2);
        end else if (16'(r_grid) > 16'(MAX_GRID)) begin
            grid = GW'(MAX_GRID);
        end else begin
            grid = GW'(r_grid);
        end
        gl = GL_W'(32'(grid) * 32'(LOOPS_PER_BOX));
    end

    // latched word
    logic             r_func;
    logic             r_ion;
    logic [5:0]       r_raw [3];
    logic [MAG_W-1:0] r_mag [3];
    logic [2:0]       r_neg;
    logic [CELL_W-1:0] start_cell [3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func   <= i_item.func;
            r_ion    <= i_item.ion_fraction > 17'(HALF_Q16);
            r_raw[0] <= i_item.cell_x;
            r_raw[1] <= i_item.cell_y;
            r_raw[2] <= i_item.cell_z;
            r_neg    <= {i_item.dir_z[15], i_item.dir_y[15], i_item.dir_x[15]};
            r_mag[0] <= i_item.dir_x[15] ? MAG_W'(~i_item.dir_x + 16'sd1) : i_item.dir_x;
            r_mag[1] <= i_item.dir_y[15] ? MAG_W'(~i_item.dir_y + 16'sd1) : i_item.dir_y;
            r_mag[2] <= i_item.dir_z[15] ? MAG_W'(~i_item.dir_z + 16'sd1) : i_item.dir_z;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            start_cell[i] = wrap_cell(r_raw[i], grid);
        end
    end

    // cell map
    logic r_map [MAP_DEPTH];
    logic r_map_bit;
    logic [ADDR_W-1:0] rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_wr) begin
            r_map[map_addr(start_cell[0], start_cell[1], start_cell[2])] <= r_ion;
        end
        r_map_bit <= r_map[rd_addr];
    end

    // walk
    logic [P_W-1:0]    r_p [3];
    logic [CELL_W-1:0] r_cell [3];
    logic [NUM_W-1:0]  r_num;
    logic [MAG_W-1:0]  r_den;
    logic [PROD_W-1:0] r_cross [3][3];
    logic              r_hit;
    logic              r_bad;

    logic [P_W-1:0]    n_p [3];
    logic [CELL_W-1:0] n_cell [3];
    logic [NUM_W-1:0]  n_num;
    logic [MAG_W-1:0]  n_den;
    logic [2:0]        nz;
    logic [2:0]        win;
    logic [1:0]        sel;
    logic              limit;

    // cross products: face time of axis i vs axis j as (2p_i+1)*mag_j
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_cross[i][j] <= PROD_W'({r_p[i], 1'b1}) * PROD_W'(r_mag[j]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nz[i] = r_mag[i] != '0;
        end
        // nearest face, ties to the lowest axis
        for (int i = 0; i < 3; i++) begin
            win[i] = nz[i];
            for (int j = 0; j < 3; j++) begin
                if (j < i && nz[j] && !(r_cross[i][j] < r_cross[j][i])) win[i] = 1'b0;
                if (j > i && nz[j] && (r_cross[j][i] < r_cross[i][j])) win[i] = 1'b0;
            end
        end
        if (win[0]) begin
            sel = 2'd0;
        end else if (win[1]) begin
            sel = 2'd1;
        end else begin
            sel = 2'd2;
        end
        n_num = {r_p[sel], 1'b1};
        n_den = r_mag[sel];
        for (int i = 0; i < 3; i++) begin
            n_p[i]    = r_p[i];
            n_cell[i] = r_cell[i];
            if (2'(i) == sel) begin
                n_p[i] = r_p[i] + 1'b1;
                if (r_neg[i]) begin
                    n_cell[i] = (r_cell[i] == '0) ? CELL_W'(grid - 1'b1)
                                                  : r_cell[i] - 1'b1;
                end else begin
                    n_cell[i] = (GW'(r_cell[i]) + 1'b1 >= grid) ? '0
                                                               : r_cell[i] + 1'b1;
                end
            end
        end
        rd_addr = map_addr(n_cell[0], n_cell[1], n_cell[2]);
        limit   = (CMP_W'(r_num) << HALF_CELL_SHIFT) >= CMP_W'(gl) * CMP_W'(r_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i]    <= '0;
                r_cell[i] <= start_cell[i];
            end
            r_bad <= nz == 3'b000;
            r_hit <= 1'b0;
        end else if (i_cmd.step) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i]    <= n_p[i];
                r_cell[i] <= n_cell[i];
            end
            r_num <= n_num;
            r_den <= n_den;
        end else if (i_cmd.check) begin
            r_hit <= limit;
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [MAG_W-1:0]  r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic [23:0]       r_path;
    logic [MAG_W:0]    trial;

    assign trial = {r_rem, r_quo[DIVD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_load_path || i_cmd.div_load_bin) begin
            r_cnt <= CNT_W'(DIVD_W);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load_path) begin
            r_rem <= '0;
            r_quo <= DIVD_W'(r_num) << PATH_SHIFT;
        end else if (i_cmd.div_load_bin) begin
            r_rem <= '0;
            r_quo <= DIVD_W'(r_num) * DIVD_W'(BIN_MUL);
        end else if (i_cmd.div_step) begin
            if (trial >= {1'b0, r_den}) begin
                r_rem <= MAG_W'(trial - {1'b0, r_den});
                r_quo <= {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                r_rem <= MAG_W'(trial);
                r_quo <= {r_quo[DIVD_W-2:0], 1'b0};
            end
        end
        if (i_cmd.save_path) begin
            r_path <= (r_quo > DIVD_W'(24'hFFFFFF)) ? 24'hFFFFFF : 24'(r_quo);
        end
    end

    // result
    logic [31:0] lim_path;
    logic [31:0] lim_bin;
    t_out_word   n_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit;
        end
    end

    always_comb begin
        lim_path = 32'(gl) * 32'd65536 - 32'd1;
        lim_bin  = 32'(gl) * 32'(BINS_PER_CELL) - 32'd1;
        n_result = '0;
        if (r_bad) begin
            n_result.bad_direction = 1'b1;
        end else if (r_hit) begin
            n_result.hit_limit   = 1'b1;
            n_result.path_length = (lim_path > 32'hFFFFFF) ? 24'hFFFFFF : 24'(lim_path);
            n_result.length_bin  = (lim_bin > 32'd1023) ? 10'd1023 : 10'(lim_bin);
        end else begin
            n_result.path_length = r_path;
            n_result.length_bin  = (r_quo > DIVD_W'(1023)) ? 10'd1023 : 10'(r_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_result <= n_result;
        end
    end

    always_comb begin
        o_status.func     = r_func;
        o_status.zero_dir = nz == 3'b000;
        o_status.stop     = limit || !r_map_bit;
        o_status.limit    = limit;
        o_status.div_done = r_cnt == '0;
    end

endmodule
`default_nettype wire

@@ hw/rtl/periodic_voxel_ray_path_length_top.sv @@
// Channel  | Ports                               | Handshake
// ---------+-------------------------------------+----------------------------------
// item in  | start, busy, i_item                 | taken when start && !busy
// config   | i_cfg_valid, o_cfg_ready, i_cfg_data| written when valid && ready
// result   | o_strobe, o_result                  | one cycle per word, no back-pressure
//
// A load writes one map cell. A trace walks face by face: the cross products are
// registered, then the nearest face is selected and its map bit read, then checked;
// two restoring divisions follow unless the walk ends at the limit or the direction
// is zero. Reset is synchronous, active low; the map keeps no reset. The result
// strobe is high for one cycle; the receiver cannot stall.
`default_nettype none
module periodic_voxel_ray_path_length_top
    import pvr_pkg::*;
#(
    parameter int MAX_GRID      = MAX_GRID_DEF,
    parameter int LOOPS_PER_BOX = LOOPS_PER_BOX_DEF,
    parameter int BINS_PER_CELL = BINS_PER_CELL_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  t_in_word   i_item,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [6:0] i_cfg_data,
    output logic       o_strobe,
    output t_out_word  o_result
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = !busy;

    pvr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    pvr_datapath #(
        .MAX_GRID      (MAX_GRID),
        .LOOPS_PER_BOX (LOOPS_PER_BOX),
        .BINS_PER_CELL (BINS_PER_CELL)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_wr   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule
`default_nettype wire

@@ verif/periodic_voxel_ray_path_length_top_test.sv @@
`timescale 1ns / 1ps
`default_nettype none
module periodic_voxel_ray_path_length_top_test
    import pvr_pkg::*;
;

    localparam int     MAP_DEPTH   = 64 * 64 * 64;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam int     LOOPS       = LOOPS_PER_BOX_DEF;
    localparam int     BINS        = BINS_PER_CELL_DEF;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_word    i_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;
    logic        o_strobe;
    t_out_word   o_result;

    periodic_voxel_ray_path_length_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // predictor state
    bit          ion_map [MAP_DEPTH];
    logic [6:0]  grid_reg;
    longint unsigned faces_crossed [3];
    int          walk_cell [3];
    logic [23:0] last_length;

    t_out_word   pending_lengths [$];
    int          error_count;
    int          idle_pct;
    longint      cycle_count;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("periodic_voxel_ray_path_length_top_test: done, errors");
            $finish;
        end
    end

    function automatic int eff_grid();
        int g;
        g = int'(grid_reg);
        if (g < 2) g = 2;
        if (g > MAX_GRID_DEF) g = MAX_GRID_DEF;
        return g;
    endfunction

    function automatic int cell_addr(int x, int y, int z);
        return (x * 64 + y) * 64 + z;
    endfunction

    // walks the ray face by face; face compares are exact rationals as in the block, the limit compare is not
    function automatic t_out_word trace_ray(t_in_word w);
        t_out_word r;
        int g, a;
        longint unsigned gl, num, den, path_v, bin_v;
        longint unsigned mag [3];
        bit neg [3];
        logic [15:0] d [3];
        bit lim;
        g = eff_grid();
        d[0] = w.dir_x; d[1] = w.dir_y; d[2] = w.dir_z;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = d[i][15];
            mag[i] = neg[i] ? (32'h10000 - d[i]) : d[i];
        end
        if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
            r.bad_direction = 1'b1;
            return r;
        end
        gl = g * LOOPS;
        walk_cell[0] = w.cell_x % g;
        walk_cell[1] = w.cell_y % g;
        walk_cell[2] = w.cell_z % g;
        for (int i = 0; i < 3; i++) faces_crossed[i] = 0;
        num = 0; den = 1; lim = 0;
        while (1) begin
            a = -1;
            for (int i = 0; i < 3; i++) begin
                if (mag[i] != 0) begin
                    if (a < 0) a = i;
                    else if ((2 * faces_crossed[i] + 1) * mag[a] <
                             (2 * faces_crossed[a] + 1) * mag[i]) a = i;
                end
            end
            num = 2 * faces_crossed[a] + 1;
            den = mag[a];
            faces_crossed[a]++;
            if (neg[a]) walk_cell[a] = (walk_cell[a] == 0) ? g - 1 : walk_cell[a] - 1;
            else walk_cell[a] = (walk_cell[a] + 1 >= g) ? 0 : walk_cell[a] + 1;
            lim = num * 8192 * 64'd1000000000 >= 64'd999999999 * gl * den;
            if (lim || !ion_map[cell_addr(walk_cell[0], walk_cell[1], walk_cell[2])]) break;
        end
        if (lim) begin
            path_v = gl * 65536 - 1;
            bin_v  = gl * BINS - 1;
        end else begin
            path_v = (num * 8192 * 65536) / den;
            bin_v  = (num * 8192 * BINS) / den;
        end
        if (path_v > 24'hFFFFFF) path_v = 24'hFFFFFF;
        if (bin_v > 1023) bin_v = 1023;
        last_length     = path_v[23:0];
        r.path_length   = path_v[23:0];
        r.length_bin    = bin_v[9:0];
        r.hit_limit     = lim;
        return r;
    endfunction

    task automatic predict(t_in_word w);
        int g;
        g = eff_grid();
        if (w.func == FUNC_LOAD)
            ion_map[cell_addr(w.cell_x % g, w.cell_y % g, w.cell_z % g)] =
                (w.ion_fraction > HALF_Q16);
        else
            pending_lengths.push_back(trace_ray(w));
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_strobe) begin
            if (pending_lengths.size() == 0) begin
                $error("unexpected result word %h", o_result);
                error_count++;
            end else begin
                exp_w = pending_lengths.pop_front();
                if (o_result.path_length !== exp_w.path_length) begin
                    $error("path_length exp %0d got %0d", exp_w.path_length, o_result.path_length);
                    error_count++;
                end
                if (o_result.length_bin !== exp_w.length_bin) begin
                    $error("length_bin exp %0d got %0d", exp_w.length_bin, o_result.length_bin);
                    error_count++;
                end
                if (o_result.hit_limit !== exp_w.hit_limit) begin
                    $error("hit_limit exp %0d got %0d", exp_w.hit_limit, o_result.hit_limit);
                    error_count++;
                end
                if (o_result.bad_direction !== exp_w.bad_direction) begin
                    $error("bad_direction exp %0d got %0d",
                           exp_w.bad_direction, o_result.bad_direction);
                    error_count++;
                end
            end
        end
    end

    task automatic send_word(t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_item <= w;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict(w);
    endtask

    function automatic t_in_word load_word(int x, int y, int z, int frac);
        t_in_word w;
        w = '0;
        w.dir_x = 16'($urandom); w.dir_y = 16'($urandom); w.dir_z = 16'($urandom);
        w.func = FUNC_LOAD;
        w.cell_x = 6'(x); w.cell_y = 6'(y); w.cell_z = 6'(z);
        w.ion_fraction = 17'(frac);
        return w;
    endfunction

    function automatic t_in_word trace_word(int x, int y, int z, int dx, int dy, int dz);
        t_in_word w;
        w.func = FUNC_TRACE;
        w.cell_x = 6'(x); w.cell_y = 6'(y); w.cell_z = 6'(z);
        w.ion_fraction = 17'($urandom);
        w.dir_x = 16'(dx); w.dir_y = 16'(dy); w.dir_z = 16'(dz);
        return w;
    endfunction

    function automatic int rand_frac();
        case ($urandom_range(9, 0))
            0: return $urandom_range(131071, 0);
            1, 2: return $urandom_range(32768, 0);
            default: return $urandom_range(65536, 32769);
        endcase
    endfunction

    function automatic int rand_comp();
        case ($urandom_range(19, 0))
            0, 1: return $urandom_range(65535, 0);
            2, 3: return 0;
            4: return $urandom_range(3, 0) - 1;
            default: return $urandom_range(32768, 0) - 16384;
        endcase
    endfunction

    // quiet the input side and let pending results and the last word finish before a register write
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_lengths.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_grid(logic [6:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        grid_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // full 64 grid: only the x row at y=z=0 is ever walked
    task automatic test_row_directed();
        for (int x = 0; x < 64; x++) send_word(load_word(x, 0, 0, 65536));
        send_word(trace_word(0, 0, 0, 16384, 0, 0));
        send_word(trace_word(63, 0, 0, -16384, 0, 0));
        send_word(trace_word(7, 0, 0, 1, 0, 0));            // nearest face past the limit
        send_word(trace_word(7, 0, 0, -32768, 0, 0));
        send_word(trace_word(9, 63, 63, 0, 0, 0));          // zero direction
        send_word(load_word(5, 0, 0, 32768));               // exactly half: neutral
        send_word(trace_word(0, 0, 0, 16384, 0, 0));
        send_word(trace_word(5, 0, 0, 12000, 0, 0));        // neutral start cell
        send_word(load_word(5, 0, 0, 32769));
        send_word(trace_word(0, 0, 0, 32767, 0, 0));
        send_word(load_word(63, 63, 63, 131071));
        send_word(load_word(63, 63, 63, 0));
    endtask

    task automatic test_row_random(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(3, 0) == 0) begin
                if ($urandom_range(1, 0))
                    send_word(load_word($urandom_range(63, 0), 0, 0, rand_frac()));
                else
                    send_word(load_word($urandom_range(63, 0), $urandom_range(63, 0),
                                        $urandom_range(63, 0), rand_frac()));
            end else begin
                send_word(trace_word($urandom_range(63, 0), 0, 0, rand_comp(), 0, 0));
            end
        end
    endtask

    task automatic test_small_grid(logic [6:0] value, int count);
        int g;
        write_grid(value);
        g = eff_grid();
        for (int x = 0; x < g; x++)
            for (int y = 0; y < g; y++)
                for (int z = 0; z < g; z++)
                    send_word(load_word(x, y, z, ($urandom_range(3, 0) == 0) ?
                                        $urandom_range(32768, 0) : 65536));
        send_word(trace_word(63, 63, 63, 16384, 16384, 16384));  // wrapped start
        send_word(trace_word(0, 0, 0, 0, 0, 0));
        for (int n = 0; n < count; n++) begin
            idle_pct = (n < count / 3) ? 0 : (n < 2 * count / 3) ? 57 : 9;
            if ($urandom_range(3, 0) == 0)
                send_word(load_word($urandom_range(63, 0), $urandom_range(63, 0),
                                    $urandom_range(63, 0), rand_frac()));
            else
                send_word(trace_word($urandom_range(63, 0), $urandom_range(63, 0),
                                     $urandom_range(63, 0), rand_comp(), rand_comp(),
                                     rand_comp()));
        end
        idle_pct = 0;
    endtask

    task automatic test_full_grid(logic [6:0] value, int count);
        write_grid(value);
        idle_pct = 57;
        test_row_random(count);
        idle_pct = 0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        grid_reg    = 7'(GRID_RESET);
        last_length = '0;
        error_count = 0;
        idle_pct    = 0;
        cycle_count = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_row_directed();
        test_row_random(60);
        test_small_grid(7'd0, 150);
        test_small_grid(7'd3, 150);
        test_small_grid(7'd5, 150);
        test_small_grid(7'd8, 150);
        test_full_grid(7'd127, 80);
        test_small_grid(7'd1, 120);
        test_small_grid(7'd2, 100);
        test_full_grid(7'd64, 60);

        drain();
        repeat (20) @(negedge i_clk);
        if (error_count == 0)
            $display("periodic_voxel_ray_path_length_top_test: done, clean");
        else
            $display("periodic_voxel_ray_path_length_top_test: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/pvr_pkg.sv
hw/rtl/pvr_ctrl.sv
hw/rtl/pvr_datapath.sv
hw/rtl/periodic_voxel_ray_path_length_top.sv
verif/periodic_voxel_ray_path_length_top_test.sv
